// ----- hw/rtl/ccp_pkg.sv -----
// shared types, constants and helpers for the phase current clarke/park block
`default_nettype none

package ccp_pkg;

    // sample and result widths
    localparam int SAMPLE_BITS = 16;
    localparam int ANG_W       = 16;
    localparam int RES_W       = 18;
    localparam int MAG_W       = 17;

    // calibration
    localparam int CAL_SAMPLES = 1000;
    localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_BITS + $clog2(CAL_SAMPLES) + 1;

    // datapath
    localparam int CORR_W = SAMPLE_BITS + 1;
    localparam int MUL_W  = (CORR_W > RES_W) ? CORR_W : RES_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int DIV_W  = ACC_W;
    localparam int TRIG_W = 16;

    // square root
    localparam int SQRT_W     = ACC_W + (ACC_W % 2);
    localparam int SQRT_STEPS = SQRT_W / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // stream packing
    localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + ANG_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 5 * RES_W + MAG_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    // fixed-point constants
    localparam int K_INV_SQRT3     = 37837;
    localparam int K_TWO_INV_SQRT3 = 75674;
    localparam int TRIG_SCALE      = 32767;
    localparam int QUARTER_TURN    = 16384;
    localparam int SIN_C0          = 148;
    localparam int SIN_C1          = 2611;
    localparam int SIN_C2          = 21167;
    localparam int SIN_C3          = 51472;
    localparam int BETA_ROUND      = 65535;

    // constant division: reciprocal for the calibration count, fold for the trig scale
    localparam int     CAL_MAG_W   = SAMPLE_BITS + $clog2(CAL_SAMPLES);
    localparam int     CAL_SHIFT   = CAL_MAG_W + $clog2(CAL_SAMPLES);
    localparam int     CAL_RECIP_W = CAL_MAG_W + 1;
    localparam longint CAL_RECIP   = ((longint'(1) << CAL_SHIFT) + CAL_SAMPLES - 1)
                                     / CAL_SAMPLES;
    localparam int     TRIG_SHIFT  = 15;

    typedef enum logic {
        KIND_CAL  = 1'b0,
        KIND_CONV = 1'b1
    } op_kind_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_FOLD,
        DV_FIX
    } div_stage_t;

    typedef struct packed {
        op_kind_t                       kind;
        logic signed [SAMPLE_BITS-1:0]  sample_a;
        logic signed [SAMPLE_BITS-1:0]  sample_b;
        logic        [ANG_W-1:0]        angle;
    } item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] alpha;
        logic signed [RES_W-1:0] beta;
        logic signed [RES_W-1:0] corrected_b;
        logic signed [RES_W-1:0] direct;
        logic signed [RES_W-1:0] quadrature;
        logic        [MAG_W-1:0] magnitude;
        logic                    cal_done;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CAL_ACC,
        ST_CAL_DIVA,
        ST_CAL_WAITA,
        ST_CAL_DIVB,
        ST_CAL_WAITB,
        ST_CV_CORR,
        ST_CV_B1,
        ST_CV_B2,
        ST_CV_B3,
        ST_TR_X2,
        ST_TR_T1,
        ST_TR_T2,
        ST_TR_T3,
        ST_TR_Y,
        ST_TR_S,
        ST_PK_D1,
        ST_PK_D2,
        ST_PK_DDIV,
        ST_PK_DWAIT,
        ST_PK_Q1,
        ST_PK_Q2,
        ST_PK_QDIV,
        ST_PK_QWAIT,
        ST_MG_1,
        ST_MG_2,
        ST_MG_SQRT,
        ST_OUT
    } eng_state_t;

    // clamp a wide signed value to the result range
    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(2 ** (RES_W - 1) - 1);
        lo = -ACC_W'(2 ** (RES_W - 1));
        if (v > hi) begin
            return hi[RES_W-1:0];
        end else if (v < lo) begin
            return lo[RES_W-1:0];
        end
        return v[RES_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ccp_front.sv -----
// front end: request intake, op classification and the short queue to the back end
`default_nettype none

module ccp_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ccp_pkg::IN_DATA_W-1:0]   s_tdata,  // sample_a, sample_b, angle
    input  wire logic                            s_tuser,  // op
    output logic                                 item_valid,
    output ccp_pkg::item_t                       item,
    input  wire logic                            item_pop
);

    ccp_pkg::item_t                 entry_reg [ccp_pkg::QUEUE_DEPTH];
    logic [ccp_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ccp_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ccp_pkg::PTR_W:0]        count_reg, count_next;
    logic                           push;
    ccp_pkg::item_t                 new_item;

    // classify the incoming request
    always_comb begin
        new_item.kind     = s_tuser ? ccp_pkg::KIND_CONV : ccp_pkg::KIND_CAL;
        new_item.sample_a = s_tdata[ccp_pkg::SAMPLE_BITS-1:0];
        new_item.sample_b = s_tdata[2*ccp_pkg::SAMPLE_BITS-1:ccp_pkg::SAMPLE_BITS];
        new_item.angle    = s_tdata[2*ccp_pkg::SAMPLE_BITS+ccp_pkg::ANG_W-1:
                                    2*ccp_pkg::SAMPLE_BITS];
    end

    assign s_tready   = (count_reg != (ccp_pkg::PTR_W+1)'(ccp_pkg::QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != '0);
    assign item       = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == ccp_pkg::PTR_W'(ccp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop) begin
            rd_ptr_next = (rd_ptr_reg == ccp_pkg::PTR_W'(ccp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !item_pop) begin
            count_next = count_reg + 1'b1;
        end else if (item_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (ccp_pkg::PTR_W+1)'(ccp_pkg::QUEUE_DEPTH))
        else $error("queue fill beyond depth");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |-> item_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ccp_div.sv -----
// constant divider: reciprocal multiply by the calibration count, shift-and-fold by the trig scale
`default_nettype none

module ccp_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [ccp_pkg::DIV_W-1:0]     dividend,
    input  wire logic                          by_cal,   // 1: calibration count, 0: trig scale
    output logic                               done,
    output logic [ccp_pkg::DIV_W-1:0]          quotient
);

    localparam int SH = ccp_pkg::TRIG_SHIFT;
    localparam int RW = ccp_pkg::DIV_W - SH + 1;
    localparam int PW = ccp_pkg::CAL_MAG_W + ccp_pkg::CAL_RECIP_W;

    ccp_pkg::div_stage_t            stage_reg, stage_next;
    logic                           by_cal_reg, by_cal_next;
    logic                           done_reg, done_next;
    logic [ccp_pkg::DIV_W-1:0]      q_reg, q_next;
    logic [RW-1:0]                  r_reg, r_next;
    logic [PW-1:0]                  prod_reg, prod_next;

    assign done     = done_reg;
    assign quotient = q_reg;

    // load, then either shift the reciprocal product or fold the remainder back in and correct
    always_comb begin
        stage_next  = stage_reg;
        by_cal_next = by_cal_reg;
        done_next   = 1'b0;
        q_next      = q_reg;
        r_next      = r_reg;
        prod_next   = prod_reg;
        unique case (stage_reg)
            ccp_pkg::DV_IDLE: begin
                if (start) begin
                    by_cal_next = by_cal;
                    prod_next   = dividend[ccp_pkg::CAL_MAG_W-1:0]
                                  * ccp_pkg::CAL_RECIP_W'(ccp_pkg::CAL_RECIP);
                    q_next      = dividend >> SH;
                    r_next      = RW'(dividend[SH-1:0]) + RW'(dividend >> SH);
                    stage_next  = ccp_pkg::DV_FOLD;
                end
            end
            ccp_pkg::DV_FOLD: begin
                if (by_cal_reg) begin
                    q_next     = ccp_pkg::DIV_W'(prod_reg >> ccp_pkg::CAL_SHIFT);
                    done_next  = 1'b1;
                    stage_next = ccp_pkg::DV_IDLE;
                end else begin
                    q_next     = q_reg + ccp_pkg::DIV_W'(r_reg >> SH);
                    r_next     = RW'(r_reg[SH-1:0]) + (r_reg >> SH);
                    stage_next = ccp_pkg::DV_FIX;
                end
            end
            ccp_pkg::DV_FIX: begin
                if (r_reg >= RW'(ccp_pkg::TRIG_SCALE)) begin
                    q_next = q_reg + 1'b1;
                end
                done_next  = 1'b1;
                stage_next = ccp_pkg::DV_IDLE;
            end
            default: begin
                stage_next = ccp_pkg::DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ccp_pkg::DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        by_cal_reg <= by_cal_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        prod_reg   <= prod_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ccp_engine.sv -----
// back end: calibration, clarke/park sequencer, magnitude and result register
`default_nettype none

module ccp_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    input  wire ccp_pkg::item_t     item,
    output logic                    item_pop,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output ccp_pkg::result_t        out_res
);

    localparam int MW = ccp_pkg::MUL_W;
    localparam int AW = ccp_pkg::ACC_W;
    localparam int TW = ccp_pkg::TRIG_W;

    ccp_pkg::eng_state_t                    state_reg, state_next;
    ccp_pkg::op_kind_t                      kind_reg, kind_next;
    logic signed [ccp_pkg::SAMPLE_BITS-1:0] a_reg, a_next, b_reg, b_next;
    logic [ccp_pkg::ANG_W-1:0]              ang_reg, ang_next;
    logic signed [ccp_pkg::SUM_W-1:0]       sum_a_reg, sum_a_next, sum_b_reg, sum_b_next;
    logic [ccp_pkg::CNT_W-1:0]              cnt_reg, cnt_next;
    logic signed [ccp_pkg::SAMPLE_BITS-1:0] off_a_reg, off_a_next, off_b_reg, off_b_next;
    logic signed [ccp_pkg::CORR_W-1:0]      ca_reg, ca_next, cb_reg, cb_next;
    logic signed [ccp_pkg::RES_W-1:0]       alpha_reg, alpha_next, beta_reg, beta_next;
    logic signed [ccp_pkg::RES_W-1:0]       cbs_reg, cbs_next;
    logic signed [ccp_pkg::RES_W-1:0]       d_reg, d_next, q_reg, q_next;
    logic signed [AW-1:0]                   acc_reg, acc_next;
    logic                                   neg_reg, neg_next;
    logic                                   cal_done_reg, cal_done_next;
    logic                                   cos_phase_reg, cos_phase_next;
    logic [TW-1:0]                          x_reg, x_next, x2_reg, x2_next;
    logic [TW-1:0]                          t_reg, t_next, y_reg, y_next;
    logic signed [TW-1:0]                   sin_reg, sin_next, cos_reg, cos_next;
    logic [ccp_pkg::SQRT_W-1:0]             rad_reg, rad_next;
    logic [ccp_pkg::REM_W-1:0]              rem_reg, rem_next;
    logic [ccp_pkg::ROOT_W-1:0]             root_reg, root_next;
    logic [ccp_pkg::STEP_W-1:0]             step_reg, step_next;
    logic                                   out_valid_reg, out_valid_next;
    ccp_pkg::result_t                       res_reg, res_next;

    logic signed [MW-1:0]                   mul_x, mul_y;
    logic signed [ccp_pkg::PROD_W-1:0]      mul_p, p_sh15;
    logic [ccp_pkg::ANG_W-1:0]              ang_eff;
    logic [1:0]                             quad;
    logic [ccp_pkg::ANG_W-3:0]              r_ang;
    logic [ccp_pkg::ANG_W-2:0]              u_ang;
    logic [TW-1:0]                          x_c;
    logic [ccp_pkg::CNT_W-1:0]              cnt_inc;
    logic signed [ccp_pkg::SUM_W-1:0]       sum_a_inc, sum_b_inc;
    logic signed [AW-1:0]                   beta_tr;
    logic [ccp_pkg::REM_W-1:0]              rem_sh, trial;
    logic signed [AW-1:0]                   div_signed;

    logic                                   div_start;
    logic [ccp_pkg::DIV_W-1:0]              div_dvd;
    logic                                   div_cal;
    logic                                   div_done;
    logic [ccp_pkg::DIV_W-1:0]              div_q;

    // shared divider for offsets and park scaling
    ccp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .by_cal   (div_cal),
        .done     (div_done),
        .quotient (div_q)
    );

    // the one shared multiplier
    assign mul_p  = mul_x * mul_y;
    assign p_sh15 = mul_p >>> 15;

    // angle folding into the first quadrant
    assign ang_eff = cos_phase_reg ? ang_reg + ccp_pkg::ANG_W'(ccp_pkg::QUARTER_TURN) : ang_reg;
    assign quad    = ang_eff[ccp_pkg::ANG_W-1:ccp_pkg::ANG_W-2];
    assign r_ang   = ang_eff[ccp_pkg::ANG_W-3:0];
    assign u_ang   = quad[0] ? (ccp_pkg::ANG_W-1)'(ccp_pkg::QUARTER_TURN) - {1'b0, r_ang}
                             : {1'b0, r_ang};
    assign x_c     = {u_ang, 1'b0};

    // calibration sums and count
    assign cnt_inc   = cnt_reg + 1'b1;
    assign sum_a_inc = sum_a_reg + ccp_pkg::SUM_W'(a_reg);
    assign sum_b_inc = sum_b_reg + ccp_pkg::SUM_W'(b_reg);

    // beta truncated toward zero
    assign beta_tr = (acc_reg < 0) ? (acc_reg + AW'(ccp_pkg::BETA_ROUND)) >>> 16
                                   : acc_reg >>> 16;

    // root step
    assign rem_sh = {rem_reg[ccp_pkg::REM_W-3:0], rad_reg[ccp_pkg::SQRT_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    assign div_signed = neg_reg ? -$signed(div_q) : $signed(div_q);

    assign item_pop  = (state_reg == ccp_pkg::ST_IDLE) && item_valid;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // sequencer: next state and datapath
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ang_next       = ang_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        cnt_next       = cnt_reg;
        off_a_next     = off_a_reg;
        off_b_next     = off_b_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        alpha_next     = alpha_reg;
        beta_next      = beta_reg;
        cbs_next       = cbs_reg;
        d_next         = d_reg;
        q_next         = q_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        cal_done_next  = cal_done_reg;
        cos_phase_next = cos_phase_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        t_next         = t_reg;
        y_next         = y_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        mul_x          = '0;
        mul_y          = '0;
        div_start      = 1'b0;
        div_dvd        = '0;
        div_cal        = 1'b0;

        // result register drains independently
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ccp_pkg::ST_IDLE: begin
                if (item_valid) begin
                    kind_next  = item.kind;
                    a_next     = item.sample_a;
                    b_next     = item.sample_b;
                    ang_next   = item.angle;
                    state_next = (item.kind == ccp_pkg::KIND_CAL) ? ccp_pkg::ST_CAL_ACC
                                                                  : ccp_pkg::ST_CV_CORR;
                end
            end
            ccp_pkg::ST_CAL_ACC: begin
                alpha_next = '0;
                beta_next  = '0;
                cbs_next   = '0;
                d_next     = '0;
                q_next     = '0;
                root_next  = '0;
                sum_a_next = sum_a_inc;
                sum_b_next = sum_b_inc;
                if (cnt_inc >= ccp_pkg::CNT_W'(ccp_pkg::CAL_SAMPLES)) begin
                    cnt_next      = '0;
                    cal_done_next = 1'b1;
                    state_next    = ccp_pkg::ST_CAL_DIVA;
                end else begin
                    cnt_next      = cnt_inc;
                    cal_done_next = 1'b0;
                    state_next    = ccp_pkg::ST_OUT;
                end
            end
            ccp_pkg::ST_CAL_DIVA: begin
                div_start  = 1'b1;
                div_dvd    = (sum_a_reg < 0) ? ccp_pkg::DIV_W'(-sum_a_reg)
                                             : ccp_pkg::DIV_W'(sum_a_reg);
                div_cal    = 1'b1;
                neg_next   = (sum_a_reg < 0);
                state_next = ccp_pkg::ST_CAL_WAITA;
            end
            ccp_pkg::ST_CAL_WAITA: begin
                if (div_done) begin
                    off_a_next = div_signed[ccp_pkg::SAMPLE_BITS-1:0];
                    state_next = ccp_pkg::ST_CAL_DIVB;
                end
            end
            ccp_pkg::ST_CAL_DIVB: begin
                div_start  = 1'b1;
                div_dvd    = (sum_b_reg < 0) ? ccp_pkg::DIV_W'(-sum_b_reg)
                                             : ccp_pkg::DIV_W'(sum_b_reg);
                div_cal    = 1'b1;
                neg_next   = (sum_b_reg < 0);
                state_next = ccp_pkg::ST_CAL_WAITB;
            end
            ccp_pkg::ST_CAL_WAITB: begin
                if (div_done) begin
                    off_b_next = div_signed[ccp_pkg::SAMPLE_BITS-1:0];
                    sum_a_next = '0;
                    sum_b_next = '0;
                    state_next = ccp_pkg::ST_OUT;
                end
            end
            ccp_pkg::ST_CV_CORR: begin
                ca_next       = ccp_pkg::CORR_W'(a_reg) - ccp_pkg::CORR_W'(off_a_reg);
                cb_next       = ccp_pkg::CORR_W'(b_reg) - ccp_pkg::CORR_W'(off_b_reg);
                cal_done_next = 1'b0;
                state_next    = ccp_pkg::ST_CV_B1;
            end
            ccp_pkg::ST_CV_B1: begin
                alpha_next = ccp_pkg::sat_res(AW'(ca_reg));
                cbs_next   = ccp_pkg::sat_res(AW'(cb_reg));
                mul_x      = MW'(ca_reg);
                mul_y      = MW'(ccp_pkg::K_INV_SQRT3);
                acc_next   = AW'(mul_p);
                state_next = ccp_pkg::ST_CV_B2;
            end
            ccp_pkg::ST_CV_B2: begin
                mul_x      = MW'(cb_reg);
                mul_y      = MW'(ccp_pkg::K_TWO_INV_SQRT3);
                acc_next   = acc_reg + AW'(mul_p);
                state_next = ccp_pkg::ST_CV_B3;
            end
            ccp_pkg::ST_CV_B3: begin
                beta_next      = ccp_pkg::sat_res(beta_tr);
                cos_phase_next = 1'b0;
                state_next     = ccp_pkg::ST_TR_X2;
            end
            ccp_pkg::ST_TR_X2: begin
                mul_x      = MW'(x_c);
                mul_y      = MW'(x_c);
                x_next     = x_c;
                x2_next    = p_sh15[TW-1:0];
                state_next = ccp_pkg::ST_TR_T1;
            end
            ccp_pkg::ST_TR_T1: begin
                mul_x      = MW'(x2_reg);
                mul_y      = MW'(ccp_pkg::SIN_C0);
                t_next     = TW'(ccp_pkg::SIN_C1) - p_sh15[TW-1:0];
                state_next = ccp_pkg::ST_TR_T2;
            end
            ccp_pkg::ST_TR_T2: begin
                mul_x      = MW'(x2_reg);
                mul_y      = MW'(t_reg);
                t_next     = TW'(ccp_pkg::SIN_C2) - p_sh15[TW-1:0];
                state_next = ccp_pkg::ST_TR_T3;
            end
            ccp_pkg::ST_TR_T3: begin
                mul_x      = MW'(x2_reg);
                mul_y      = MW'(t_reg);
                t_next     = TW'(ccp_pkg::SIN_C3) - p_sh15[TW-1:0];
                state_next = ccp_pkg::ST_TR_Y;
            end
            ccp_pkg::ST_TR_Y: begin
                mul_x      = MW'(x_reg);
                mul_y      = MW'(t_reg);
                y_next     = p_sh15[TW-1:0];
                state_next = ccp_pkg::ST_TR_S;
            end
            ccp_pkg::ST_TR_S: begin
                mul_x = MW'(y_reg);
                mul_y = MW'(ccp_pkg::TRIG_SCALE);
                if (cos_phase_reg) begin
                    cos_next   = quad[1] ? -$signed(p_sh15[TW-1:0]) : $signed(p_sh15[TW-1:0]);
                    state_next = ccp_pkg::ST_PK_D1;
                end else begin
                    sin_next       = quad[1] ? -$signed(p_sh15[TW-1:0])
                                             : $signed(p_sh15[TW-1:0]);
                    cos_phase_next = 1'b1;
                    state_next     = ccp_pkg::ST_TR_X2;
                end
            end
            ccp_pkg::ST_PK_D1: begin
                mul_x      = MW'(cos_reg);
                mul_y      = MW'(alpha_reg);
                acc_next   = AW'(mul_p);
                state_next = ccp_pkg::ST_PK_D2;
            end
            ccp_pkg::ST_PK_D2: begin
                mul_x      = MW'(sin_reg);
                mul_y      = MW'(beta_reg);
                acc_next   = acc_reg + AW'(mul_p);
                state_next = ccp_pkg::ST_PK_DDIV;
            end
            ccp_pkg::ST_PK_DDIV: begin
                div_start  = 1'b1;
                div_dvd    = (acc_reg < 0) ? ccp_pkg::DIV_W'(-acc_reg) : ccp_pkg::DIV_W'(acc_reg);
                div_cal    = 1'b0;
                neg_next   = (acc_reg < 0);
                state_next = ccp_pkg::ST_PK_DWAIT;
            end
            ccp_pkg::ST_PK_DWAIT: begin
                if (div_done) begin
                    d_next     = ccp_pkg::sat_res(div_signed);
                    state_next = ccp_pkg::ST_PK_Q1;
                end
            end
            ccp_pkg::ST_PK_Q1: begin
                mul_x      = MW'(cos_reg);
                mul_y      = MW'(beta_reg);
                acc_next   = AW'(mul_p);
                state_next = ccp_pkg::ST_PK_Q2;
            end
            ccp_pkg::ST_PK_Q2: begin
                mul_x      = MW'(sin_reg);
                mul_y      = MW'(alpha_reg);
                acc_next   = acc_reg - AW'(mul_p);
                state_next = ccp_pkg::ST_PK_QDIV;
            end
            ccp_pkg::ST_PK_QDIV: begin
                div_start  = 1'b1;
                div_dvd    = (acc_reg < 0) ? ccp_pkg::DIV_W'(-acc_reg) : ccp_pkg::DIV_W'(acc_reg);
                div_cal    = 1'b0;
                neg_next   = (acc_reg < 0);
                state_next = ccp_pkg::ST_PK_QWAIT;
            end
            ccp_pkg::ST_PK_QWAIT: begin
                if (div_done) begin
                    q_next     = ccp_pkg::sat_res(div_signed);
                    state_next = ccp_pkg::ST_MG_1;
                end
            end
            ccp_pkg::ST_MG_1: begin
                mul_x      = MW'(alpha_reg);
                mul_y      = MW'(alpha_reg);
                acc_next   = AW'(mul_p);
                state_next = ccp_pkg::ST_MG_2;
            end
            ccp_pkg::ST_MG_2: begin
                mul_x      = MW'(beta_reg);
                mul_y      = MW'(beta_reg);
                rad_next   = ccp_pkg::SQRT_W'(unsigned'(acc_reg + AW'(mul_p)));
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = ccp_pkg::ST_MG_SQRT;
            end
            ccp_pkg::ST_MG_SQRT: begin
                rad_next = rad_reg << 2;
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ccp_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ccp_pkg::ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == ccp_pkg::STEP_W'(ccp_pkg::SQRT_STEPS - 1)) begin
                    state_next = ccp_pkg::ST_OUT;
                end
            end
            ccp_pkg::ST_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    res_next.alpha       = alpha_reg;
                    res_next.beta        = beta_reg;
                    res_next.corrected_b = cbs_reg;
                    res_next.direct      = d_reg;
                    res_next.quadrature  = q_reg;
                    res_next.magnitude   = (root_reg > ccp_pkg::ROOT_W'(2 ** ccp_pkg::MAG_W - 1))
                                           ? '1 : root_reg[ccp_pkg::MAG_W-1:0];
                    res_next.cal_done    = (kind_reg == ccp_pkg::KIND_CAL) && cal_done_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ccp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ccp_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ccp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            cnt_reg       <= '0;
            off_a_reg     <= '0;
            off_b_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            cnt_reg       <= cnt_next;
            off_a_reg     <= off_a_next;
            off_b_reg     <= off_b_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        ang_reg       <= ang_next;
        ca_reg        <= ca_next;
        cb_reg        <= cb_next;
        alpha_reg     <= alpha_next;
        beta_reg      <= beta_next;
        cbs_reg       <= cbs_next;
        d_reg         <= d_next;
        q_reg         <= q_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        cal_done_reg  <= cal_done_next;
        cos_phase_reg <= cos_phase_next;
        x_reg         <= x_next;
        x2_reg        <= x2_next;
        t_reg         <= t_next;
        y_reg         <= y_next;
        sin_reg       <= sin_next;
        cos_reg       <= cos_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        step_reg      <= step_next;
        res_reg       <= res_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < ccp_pkg::CNT_W'(ccp_pkg::CAL_SAMPLES))
        else $error("calibration count reached its limit");
    a_cal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.cal_done) |-> (res_reg.magnitude == '0 &&
                                                 res_reg.alpha == '0))
        else $error("calibration result carries data");
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == ccp_pkg::ST_OUT)
        else $error("result appeared outside the output step");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/phase_current_clarke_park.sv -----
// top level of the phase current clarke/park block
`default_nettype none

// Phase current Clarke/Park transform. Each request carries phase A and B
// samples, an electrical angle (65536 = one turn) and an op in tuser: op 0
// accumulates a calibration sample, and the request that completes the
// calibration count loads the offsets and returns cal_done; op 1 removes the
// offsets and returns alpha, beta, corrected B, d, q and the vector magnitude.
// Every request gives exactly one result. A two-entry queue decouples intake
// from the sequencer, and a result register lets the next request start
// while a result waits. Requests are handled one at a time. A calibration
// sample is added to the sums; the one that completes the calibration count
// also runs two offset divisions by reciprocal multiplication. A conversion
// runs the offset correction, the Clarke step, the two sine evaluations on
// the shared multiplier, the two Park divisions on the shift-and-fold
// divider and the 19-step square root for the magnitude. The output step
// stalls only while the result register still holds a result.

module phase_current_clarke_park (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ccp_pkg::IN_DATA_W-1:0]    s_tdata,  // sample_a, sample_b, angle
    input  wire logic                             s_tuser,  // op
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ccp_pkg::OUT_DATA_W-1:0]        m_tdata,  // alpha, beta, corrected_b,
                                                            // direct, quadrature, magnitude
    output logic                                  m_tuser   // cal_done
);

    logic               item_valid;
    ccp_pkg::item_t     item;
    logic               item_pop;
    ccp_pkg::result_t   res;

    // intake and queue
    ccp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // calibration and transform sequencer
    ccp_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_res    (res)
    );

    // result packing
    assign m_tdata = {ccp_pkg::OUT_PAD_W'(0), res.magnitude, res.quadrature, res.direct,
                      res.corrected_b, res.beta, res.alpha};
    assign m_tuser = res.cal_done;

endmodule

`default_nettype wire

// ----- test/ccp_checker.sv -----
// stream monitor, current transform predictor and result comparison
`timescale 1ns / 100ps

module ccp_checker
    import ccp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  m_tuser,
    output int                         fail_count,
    output int                         pending
);

    // own copy of the calibration state
    longint  acc_a;
    longint  acc_b;
    int      samples_taken;
    longint  offs_a;
    longint  offs_b;
    result_t awaited_results[$];

    function automatic longint clamp18(input longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    // quarter-wave polynomial sine, scaled to 32767
    function automatic longint quarter_wave(input longint u);
        longint x;
        longint x2;
        longint t;
        longint y;
        x  = u * 2;
        x2 = (x * x) >>> 15;
        t  = SIN_C1 - ((x2 * SIN_C0) >>> 15);
        t  = SIN_C2 - ((x2 * t) >>> 15);
        t  = SIN_C3 - ((x2 * t) >>> 15);
        y  = (x * t) >>> 15;
        return (y * TRIG_SCALE) >>> 15;
    endfunction

    function automatic longint sine_of(input logic [15:0] ang);
        longint m;
        if (ang[14]) m = quarter_wave(16384 - longint'(ang[13:0]));
        else         m = quarter_wave(longint'(ang[13:0]));
        return ang[15] ? -m : m;
    endfunction

    function automatic longint root_floor(input longint n);
        longint r;
        longint b;
        r = 0;
        for (b = 1 << 20; b > 0; b = b >> 1) begin
            if ((r + b) * (r + b) <= n) r = r + b;
        end
        return r;
    endfunction

    // expected result for one accepted request, updating calibration state
    function automatic result_t transform_sample(input item_t it);
        result_t res;
        longint ca, cb, al, be, s, c, mg;
        res = '0;
        if (it.kind == KIND_CAL) begin
            acc_a = acc_a + longint'(it.sample_a);
            acc_b = acc_b + longint'(it.sample_b);
            samples_taken++;
            if (samples_taken >= CAL_SAMPLES) begin
                offs_a = acc_a / CAL_SAMPLES;
                offs_b = acc_b / CAL_SAMPLES;
                acc_a = 0;
                acc_b = 0;
                samples_taken = 0;
                res.cal_done = 1'b1;
            end
        end else begin
            ca = longint'(it.sample_a) - offs_a;
            cb = longint'(it.sample_b) - offs_b;
            al = clamp18(ca);
            be = clamp18((K_INV_SQRT3 * ca + K_TWO_INV_SQRT3 * cb) / 65536);
            s  = sine_of(it.angle);
            c  = sine_of(it.angle + 16'(QUARTER_TURN));
            mg = root_floor(al * al + be * be);
            if (mg > 131071) mg = 131071;
            res.alpha       = RES_W'(al);
            res.beta        = RES_W'(be);
            res.corrected_b = RES_W'(clamp18(cb));
            res.direct      = RES_W'(clamp18((c * al + s * be) / TRIG_SCALE));
            res.quadrature  = RES_W'(clamp18((c * be - s * al) / TRIG_SCALE));
            res.magnitude   = MAG_W'(mg);
        end
        return res;
    endfunction

    assign pending = awaited_results.size();

    // watch both channels at each edge
    always @(posedge aclk) begin
        item_t   it;
        result_t got;
        result_t want;
        if (!aresetn) begin
            acc_a = 0;
            acc_b = 0;
            samples_taken = 0;
            offs_a = 0;
            offs_b = 0;
            fail_count = 0;
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                it.kind     = op_kind_t'(s_tuser);
                it.sample_a = s_tdata[15:0];
                it.sample_b = s_tdata[31:16];
                it.angle    = s_tdata[47:32];
                awaited_results.push_back(transform_sample(it));
            end
            if (m_tvalid && m_tready) begin
                got.alpha       = m_tdata[17:0];
                got.beta        = m_tdata[35:18];
                got.corrected_b = m_tdata[53:36];
                got.direct      = m_tdata[71:54];
                got.quadrature  = m_tdata[89:72];
                got.magnitude   = m_tdata[106:90];
                got.cal_done    = m_tuser;
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: a %0d/%0d b %0d/%0d cb %0d/%0d d %0d/%0d q %0d/%0d m %0d/%0d c %0d/%0d",
                                     want.alpha, got.alpha, want.beta, got.beta,
                                     want.corrected_b, got.corrected_b,
                                     want.direct, got.direct, want.quadrature, got.quadrature,
                                     want.magnitude, got.magnitude,
                                     want.cal_done, got.cal_done);
                    end
                end
            end
        end
    end

endmodule

// ----- test/phase_current_clarke_park_test.sv -----
// stimulus, clocking and verdict for the phase current clarke/park block
`timescale 1ns / 100ps

module phase_current_clarke_park_test;
    import ccp_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // sample_a, sample_b, angle
    logic                  s_tuser;   // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // alpha, beta, corrected_b, direct, quadrature, magnitude
    logic                  m_tuser;   // cal_done
    int                    fail_count;
    int                    pending;
    int                    burst_left;
    int                    stall_left;
    int                    stall_mode;

    phase_current_clarke_park uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    ccp_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // receiver stalls in changing patterns
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(8, 80);
            stall_mode <= $urandom_range(0, 3);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= stall_left[0];
            2: m_tready <= (stall_left[2:0] != 3'd0);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // one request, in bursts with random gaps
    task automatic send_request(input op_kind_t k, input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] ang);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ang, b, a};
        s_tuser  <= k;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] edge_vals [4];
        logic [15:0] angs [6];
        int          bias_a, bias_b, spread;
        op_kind_t    k;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= KIND_CAL;
        m_tready   <= 1'b0;
        stall_left <= 0;
        stall_mode <= 0;
        aresetn    <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sample extremes at the quadrant boundaries and at two other angles, offsets still zero
        edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        angs = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535, 16'd8192};
        for (int i = 0; i < 16; i++)
            send_request(KIND_CONV, edge_vals[i % 4], edge_vals[(i / 4) % 4], angs[i % 6]);
        // a few partial calibration samples, then convert with old offsets
        for (int i = 0; i < 4; i++) send_request(KIND_CAL, edge_vals[i], edge_vals[3 - i], 16'd0);
        send_request(KIND_CONV, 16'h7fff, 16'h8000, 16'd40000);

        // random part: calibration runs with a bias, mixed with conversions
        bias_a = 0;
        bias_b = 0;
        spread = 100;
        for (int i = 0; i < 1350; i++) begin
            if (i % 150 == 0) begin
                bias_a = $urandom_range(0, 65535) - 32768;
                bias_b = $urandom_range(0, 65535) - 32768;
                spread = $urandom_range(0, 1) ? 64 : 4000;
            end
            if (i == 700) drain_results();
            k = ($urandom_range(0, 99) < 78) ? KIND_CAL : KIND_CONV;
            if (k == KIND_CAL || $urandom_range(0, 1))
                send_request(k, 16'(bias_a + $urandom_range(0, 2 * spread) - spread),
                             16'(bias_b + $urandom_range(0, 2 * spread) - spread),
                             16'($urandom_range(0, 65535)));
            else
                send_request(k, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)));
        end
        drain_results();

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_front.sv
hw/rtl/ccp_div.sv
hw/rtl/ccp_engine.sv
hw/rtl/phase_current_clarke_park.sv
test/ccp_checker.sv
test/phase_current_clarke_park_test.sv
